@@ sv/sha256_pkg.sv @@
package sha256_pkg;

   localparam int WORD_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 61;
   localparam int HASH_WORDS  = 8;
   localparam int SCHED_WORDS = 16;
   localparam int ROUNDS      = 64;
   localparam int FILL_W      = $clog2(ROUNDS);
   localparam int WIDX_W      = $clog2(SCHED_WORDS);
   localparam int DIDX_W      = $clog2(HASH_WORDS);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [HASH_WORDS-1:0][WORD_W-1:0] hash_type;

   // Byte position in the block at which the length no longer fits behind the pad byte.
   localparam logic [FILL_W-1:0] LEN_SPLIT = FILL_W'(56);
   localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h80;

   // Initial chaining value, word 0 in the lowest slot.
   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Schedule window operations.
   localparam logic [2:0] SCHED_HOLD  = 3'd0;
   localparam logic [2:0] SCHED_BYTE  = 3'd1;
   localparam logic [2:0] SCHED_PAD   = 3'd2;
   localparam logic [2:0] SCHED_LEN   = 3'd3;
   localparam logic [2:0] SCHED_SHIFT = 3'd4;

   typedef struct packed {
      logic [2:0]        op;
      logic [FILL_W-1:0] fill;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  length;
   } sched_cmd_type;

   typedef struct packed {
      logic load;
      logic step;
   } round_cmd_type;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

@@ sv/sha256_req_if.sv @@
interface sha256_req_if import sha256_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              byte_present;
   logic              message_end;

   modport source (output valid, data_byte, byte_present, message_end, input ready);
   modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

@@ sv/sha256_rsp_if.sv @@
interface sha256_rsp_if import sha256_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] digest_word;
   logic [DIDX_W-1:0] word_index;
   logic              last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ sv/sha256_sched.sv @@
module sha256_sched import sha256_pkg::*; (
   input  logic          clock,
   input  sched_cmd_type cmd,
   output word_type      w_cur
);

   word_type win_ff [SCHED_WORDS];
   word_type win_in [SCHED_WORDS];

   logic [WIDX_W-1:0] word_sel;
   logic [1:0]        lane_sel;
   word_type          len_hi;
   word_type          len_lo;

   assign word_sel = cmd.fill[FILL_W-1:2];
   assign lane_sel = cmd.fill[1:0];
   assign len_hi   = cmd.length[LEN_W-1:LEN_W-WORD_W];
   assign len_lo   = {cmd.length[LEN_W-WORD_W-1:0], 3'b000};

   always_comb begin
      win_in = win_ff;
      unique case (cmd.op)
         SCHED_BYTE: begin
            for (int j = 0; j < SCHED_WORDS; j++) begin
               for (int b = 0; b < 4; b++) begin
                  if (WIDX_W'(j) == word_sel && 2'(b) == lane_sel) begin
                     win_in[j][8*(3-b) +: 8] = cmd.data;
                  end
               end
            end
         end
         SCHED_PAD: begin
            // Pad byte at fill, zeros behind, length if room.
            for (int j = 0; j < SCHED_WORDS; j++) begin
               if (WIDX_W'(j) > word_sel) begin
                  win_in[j] = '0;
               end else if (WIDX_W'(j) == word_sel) begin
                  for (int b = 0; b < 4; b++) begin
                     if (2'(b) == lane_sel) begin
                        win_in[j][8*(3-b) +: 8] = PAD_BYTE;
                     end else if (2'(b) > lane_sel) begin
                        win_in[j][8*(3-b) +: 8] = '0;
                     end
                  end
               end
            end
            if (cmd.fill < LEN_SPLIT) begin
               win_in[SCHED_WORDS-2] = len_hi;
               win_in[SCHED_WORDS-1] = len_lo;
            end
         end
         SCHED_LEN: begin
            for (int j = 0; j < SCHED_WORDS; j++) begin
               win_in[j] = '0;
            end
            win_in[SCHED_WORDS-2] = len_hi;
            win_in[SCHED_WORDS-1] = len_lo;
         end
         SCHED_SHIFT: begin
            for (int j = 0; j < SCHED_WORDS - 1; j++) begin
               win_in[j] = win_ff[j+1];
            end
            win_in[SCHED_WORDS-1] = small_sigma1(win_ff[14]) + win_ff[9]
                                  + small_sigma0(win_ff[1]) + win_ff[0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign w_cur = win_ff[0];

endmodule

@@ sv/sha256_round.sv @@
module sha256_round import sha256_pkg::*; (
   input  logic          clock,
   input  round_cmd_type cmd,
   input  hash_type      init_vars,
   input  word_type      k_word,
   input  word_type      w_word,
   output hash_type      vars
);

   hash_type vars_ff;
   hash_type vars_in;
   word_type t1;
   word_type t2;

   always_comb begin
      t1 = vars_ff[7] + big_sigma1(vars_ff[4])
         + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6])) + k_word + w_word;
      t2 = big_sigma0(vars_ff[0])
         + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]));
      vars_in = vars_ff;
      priority if (cmd.load) begin
         vars_in = init_vars;
      end else if (cmd.step) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   assign vars = vars_ff;

endmodule

@@ sv/sha256_hash.sv @@
// SHA-256 engine that takes a message one byte item at a time and returns the
// digest as eight 32-bit word items, word 0 first, the eighth marked last_word.
// An item with message_end set closes the message after its byte; an end item
// with byte_present clear adds no byte, so an empty message is legal. The 64th
// byte of a block starts the compression: a load of the working variables, the
// rounds of the single round unit (one round per cycle, with the message schedule
// shifting alongside) and an add into the chaining value, during which req ready
// is low. Closing a message costs a padding step, one compression (two
// compressions and a length step between them when 56 or more bytes of the
// last block are used) and a hand-over of the digest to the output buffer. The
// digest waits in its own buffer, so the next message can stream in while the
// words are being taken; a second digest waits only if the buffer is still
// draining. The bit length wraps modulo 2^64.
module sha256_hash import sha256_pkg::*; (
   input logic         clock,
   input logic         reset,
   sha256_req_if.sink  req_ch,
   sha256_rsp_if.source rsp_ch
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_LEN   = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // What follows the compression of the current block.
   localparam logic [1:0] BLK_DATA  = 2'd0;
   localparam logic [1:0] BLK_EXTRA = 2'd1;
   localparam logic [1:0] BLK_FINAL = 2'd2;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic              end_pend_ff, end_pend_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [FILL_W-1:0] round_ff, round_in;
   hash_type          hash_ff, hash_in;
   hash_type          out_buf_ff, out_buf_in;
   logic              out_valid_ff, out_valid_in;
   logic [DIDX_W-1:0] out_idx_ff, out_idx_in;

   sched_cmd_type     sched_cmd;
   round_cmd_type     round_cmd;
   word_type          w_cur;
   word_type          k_word;
   hash_type          vars;

   logic              req_take;
   logic              rsp_take;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;

   assign k_word = ROUND_K[round_ff];

   sha256_sched u_sched (
      .clock (clock),
      .cmd   (sched_cmd),
      .w_cur (w_cur)
   );

   sha256_round u_round (
      .clock     (clock),
      .cmd       (round_cmd),
      .init_vars (hash_ff),
      .k_word    (k_word),
      .w_word    (w_cur),
      .vars      (vars)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      end_pend_in  = end_pend_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      hash_in      = hash_ff;
      out_buf_in   = out_buf_ff;
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;

      sched_cmd.op     = SCHED_HOLD;
      sched_cmd.fill   = fill_ff;
      sched_cmd.data   = req_ch.data_byte;
      sched_cmd.length = len_ff;
      round_cmd        = '0;

      // Digest words leave one per handshake from the bottom of the buffer.
      if (rsp_take) begin
         out_buf_in = {WORD_W'(0), out_buf_ff[HASH_WORDS-1:1]};
         out_idx_in = out_idx_ff + DIDX_W'(1);
         if (out_idx_ff == DIDX_W'(HASH_WORDS - 1)) begin
            out_valid_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_ch.byte_present) begin
                  sched_cmd.op = SCHED_BYTE;
                  fill_in      = fill_ff + FILL_W'(1);
                  len_in       = len_ff + LEN_W'(1);
                  if (fill_ff == FILL_W'(ROUNDS - 1)) begin
                     // Block full: compress it, and pad afterwards if this item ends.
                     kind_in     = BLK_DATA;
                     end_pend_in = req_ch.message_end;
                     state_in    = S_LOAD;
                  end else if (req_ch.message_end) begin
                     state_in = S_PAD;
                  end
               end else if (req_ch.message_end) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            sched_cmd.op = SCHED_PAD;
            end_pend_in  = 1'b0;
            kind_in      = (fill_ff >= LEN_SPLIT) ? BLK_EXTRA : BLK_FINAL;
            state_in     = S_LOAD;
         end
         S_LEN: begin
            sched_cmd.op = SCHED_LEN;
            kind_in      = BLK_FINAL;
            state_in     = S_LOAD;
         end
         S_LOAD: begin
            round_cmd.load = 1'b1;
            round_in       = '0;
            state_in       = S_ROUND;
         end
         S_ROUND: begin
            round_cmd.step = 1'b1;
            sched_cmd.op   = SCHED_SHIFT;
            round_in       = round_ff + FILL_W'(1);
            if (round_ff == FILL_W'(ROUNDS - 1)) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               hash_in[i] = hash_ff[i] + vars[i];
            end
            unique case (kind_ff)
               BLK_DATA:  state_in = end_pend_ff ? S_PAD : S_IDLE;
               BLK_EXTRA: state_in = S_LEN;
               BLK_FINAL: state_in = S_DONE;
               default:   state_in = S_IDLE;
            endcase
         end
         S_DONE: begin
            // Hand the digest over once the previous one has fully drained.
            if (!out_valid_ff) begin
               out_buf_in   = hash_ff;
               out_valid_in = 1'b1;
               out_idx_in   = '0;
               hash_in      = INIT_HASH;
               fill_in      = '0;
               len_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= BLK_DATA;
         end_pend_ff  <= 1'b0;
         fill_ff      <= '0;
         len_ff       <= '0;
         round_ff     <= '0;
         hash_ff      <= INIT_HASH;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         end_pend_ff  <= end_pend_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         round_ff     <= round_in;
         hash_ff      <= hash_in;
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_buf_ff <= out_buf_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.digest_word = out_buf_ff[0];
   assign rsp_ch.word_index  = out_idx_ff;
   assign rsp_ch.last_word   = (out_idx_ff == DIDX_W'(HASH_WORDS - 1));

   // The round counter ends a compression after exactly 64 rounds.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff == FILL_W'(ROUNDS - 1)) |=> (state_ff == S_ADD))
      else $error("compression did not end after the last round");

   // The 64th byte of a block starts a compression with an empty fill.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.byte_present && fill_ff == FILL_W'(ROUNDS - 1))
      |=> (state_ff == S_LOAD && fill_ff == '0))
      else $error("full block did not start a compression");

   // A finished digest never overwrites one that is still being read out.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_valid_ff) |=> (state_ff == S_DONE))
      else $error("digest handed over while output buffer busy");

endmodule
